>>> rtl/reorder_buffer_cumulative_ack_assert.svh
// Assertion macros for the reorder buffer RTL.
// Needs i_clk and i_rst_n in the module that includes it.
`ifndef REORDER_BUFFER_CUMULATIVE_ACK_ASSERT_SVH
`define REORDER_BUFFER_CUMULATIVE_ACK_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RUC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("reorder buffer check failed");

// next-cycle implication, checked out of reset
`define RUC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("reorder buffer check failed");

`endif

>>> rtl/ruc_pkg.sv
// Shared types and constants for the reorder buffer with cumulative ack.
// No dependencies; the files that use it refer to it by scoped names.
`timescale 1ns / 1ps
package ruc_pkg;

    localparam int WINDOW      = 32;
    localparam int SLOT_W      = $clog2(WINDOW);
    localparam int SEQ_W       = 16;
    localparam int LEN_W       = 11;
    localparam int TAG_W       = 8;
    localparam int PAYLOAD_MAX = 1024;
    localparam int SEQ_RESET   = 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_IGNORE,
        CMD_HOLD,
        CMD_DELIVER
    } t_cmd_kind;

    typedef enum logic {
        KIND_DELIVER = 1'b0,
        KIND_ACK     = 1'b1
    } t_res_kind;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
        logic [TAG_W-1:0] tag;
        logic             last;
    } t_seg;

    typedef struct packed {
        t_cmd_kind         kind;
        t_seg              seg;
        logic [SLOT_W-1:0] offset;
    } t_cmd;

    typedef struct packed {
        logic [SEQ_W-1:0] next_expected;
        logic             done;
        logic             busy;
    } t_back_stat;

endpackage

>>> rtl/ruc_front.sv
// Front end: registers an accepted segment, saturates its length and
// classifies it against the back end's window state. Uses ruc_pkg.
`timescale 1ns / 1ps
module ruc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  ruc_pkg::t_seg       i_seg,
    input  ruc_pkg::t_back_stat i_stat,
    output logic                o_valid,
    output ruc_pkg::t_cmd       o_cmd
);

    logic                       r_valid;
    ruc_pkg::t_seg              r_seg;
    logic [ruc_pkg::SEQ_W-1:0]  w_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_accept;
        end
        if (i_accept) begin
            r_seg <= i_seg;
            if (i_seg.len > ruc_pkg::LEN_W'(ruc_pkg::PAYLOAD_MAX)) begin
                r_seg.len <= ruc_pkg::LEN_W'(ruc_pkg::PAYLOAD_MAX);
            end
        end
    end

    // modular distance ahead of the expected number
    assign w_diff = r_seg.seq - i_stat.next_expected;

    always_comb begin
        o_cmd.seg    = r_seg;
        o_cmd.offset = w_diff[ruc_pkg::SLOT_W-1:0];
        priority if (i_stat.done) begin
            o_cmd.kind = ruc_pkg::CMD_IGNORE;
        end else if (w_diff == '0) begin
            o_cmd.kind = ruc_pkg::CMD_DELIVER;
        end else if (w_diff < ruc_pkg::SEQ_W'(ruc_pkg::WINDOW)) begin
            o_cmd.kind = ruc_pkg::CMD_HOLD;
        end else begin
            o_cmd.kind = ruc_pkg::CMD_IGNORE;
        end
    end

    assign o_valid = r_valid;

endmodule

>>> rtl/ruc_queue.sv
// Short command queue between the front end and the back end.
// Show-ahead output; uses ruc_pkg.
`timescale 1ns / 1ps
module ruc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ruc_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output ruc_pkg::t_cmd o_cmd,
    output logic          o_empty
);

    ruc_pkg::t_cmd               r_mem [ruc_pkg::QUEUE_DEPTH];
    logic [ruc_pkg::QPTR_W-1:0]  r_wr;
    logic [ruc_pkg::QPTR_W-1:0]  r_rd;
    logic [ruc_pkg::QCNT_W-1:0]  r_cnt;
    logic                        w_push;
    logic                        w_pop;

    assign w_push = i_push && (r_cnt != ruc_pkg::QCNT_W'(ruc_pkg::QUEUE_DEPTH));
    assign w_pop  = i_pop && (r_cnt != '0);

    function automatic logic [ruc_pkg::QPTR_W-1:0] ptr_inc(
        input logic [ruc_pkg::QPTR_W-1:0] p
    );
        ptr_inc = (p == ruc_pkg::QPTR_W'(ruc_pkg::QUEUE_DEPTH - 1))
                  ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (w_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            r_cnt <= r_cnt + ruc_pkg::QCNT_W'(w_push) - ruc_pkg::QCNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_cmd   = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);

endmodule

>>> rtl/ruc_back.sv
// Back end: window state, slot memory and the result sequencer that
// delivers, drains held segments and acks. Uses ruc_pkg and the assert macros.
`timescale 1ns / 1ps
`include "reorder_buffer_cumulative_ack_assert.svh"
module ruc_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ruc_pkg::t_cmd              i_cmd,
    input  logic                       i_empty,
    output logic                       o_pop,
    output ruc_pkg::t_back_stat        o_stat,
    output logic                       o_strobe,
    output logic                       o_kind,
    output logic [ruc_pkg::SEQ_W-1:0]  o_number,
    output logic [ruc_pkg::LEN_W-1:0]  o_out_length,
    output logic [ruc_pkg::TAG_W-1:0]  o_out_tag,
    output logic                       o_final_res,
    output logic                       o_run_end
);

    typedef enum logic {
        S_IDLE,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic [ruc_pkg::LEN_W-1:0] len;
        logic [ruc_pkg::TAG_W-1:0] tag;
        logic                      last;
    } t_slot;

    t_state                       r_state;
    logic [ruc_pkg::SEQ_W-1:0]    r_next;
    logic                         r_done;
    logic [ruc_pkg::SLOT_W-1:0]   r_head;
    logic [ruc_pkg::SLOT_W-1:0]   n_head;
    logic [ruc_pkg::WINDOW-1:0]   r_valid;
    t_slot                        r_mem [ruc_pkg::WINDOW];
    t_slot                        r_rd;
    logic [ruc_pkg::SLOT_W:0]     w_sum;
    logic [ruc_pkg::SLOT_W-1:0]   w_slot;
    logic [ruc_pkg::SLOT_W-1:0]   w_head_inc;
    logic                         w_hold;
    logic                         w_adv;

    assign o_pop  = (r_state == S_IDLE) && !i_empty;
    assign w_hold = o_pop && (i_cmd.kind == ruc_pkg::CMD_HOLD);

    // slot for a held segment: head plus offset, wrapped once
    assign w_sum  = {1'b0, r_head} + {1'b0, i_cmd.offset};
    assign w_slot = (w_sum >= (ruc_pkg::SLOT_W + 1)'(ruc_pkg::WINDOW))
                    ? ruc_pkg::SLOT_W'(w_sum - (ruc_pkg::SLOT_W + 1)'(ruc_pkg::WINDOW))
                    : w_sum[ruc_pkg::SLOT_W-1:0];

    assign w_head_inc = (r_head == ruc_pkg::SLOT_W'(ruc_pkg::WINDOW - 1))
                        ? '0 : r_head + 1'b1;

    assign w_adv = (o_pop && (i_cmd.kind == ruc_pkg::CMD_DELIVER))
                   || ((r_state == S_DRAIN) && r_valid[r_head]);

    always_comb begin
        n_head = r_head;
        if (w_adv) begin
            n_head = w_head_inc;
        end
    end

    // slot memory; read data always tracks the entry at head
    always_ff @(posedge i_clk) begin
        if (w_hold) begin
            r_mem[w_slot] <= '{len: i_cmd.seg.len, tag: i_cmd.seg.tag,
                               last: i_cmd.seg.last};
        end
        r_rd <= r_mem[n_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_next   <= ruc_pkg::SEQ_W'(ruc_pkg::SEQ_RESET);
            r_done   <= 1'b0;
            r_head   <= '0;
            r_valid  <= '0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            r_head   <= n_head;
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        o_strobe <= 1'b1;
                        unique case (i_cmd.kind)
                            ruc_pkg::CMD_DELIVER: begin
                                r_valid[r_head] <= 1'b0;
                                o_kind       <= ruc_pkg::KIND_DELIVER;
                                o_number     <= i_cmd.seg.seq;
                                o_out_length <= i_cmd.seg.len;
                                o_out_tag    <= i_cmd.seg.tag;
                                o_final_res  <= i_cmd.seg.last;
                                o_run_end    <= 1'b0;
                                r_done       <= r_done | i_cmd.seg.last;
                                r_next       <= r_next + 1'b1;
                                r_state      <= S_DRAIN;
                            end
                            ruc_pkg::CMD_HOLD, ruc_pkg::CMD_IGNORE: begin
                                if (w_hold) begin
                                    r_valid[w_slot] <= 1'b1;
                                end
                                o_kind       <= ruc_pkg::KIND_ACK;
                                o_number     <= r_next;
                                o_out_length <= '0;
                                o_out_tag    <= '0;
                                o_final_res  <= r_done;
                                o_run_end    <= 1'b1;
                            end
                            default: begin
                                o_strobe <= 1'b0;
                            end
                        endcase
                    end
                end
                S_DRAIN: begin
                    o_strobe <= 1'b1;
                    if (r_valid[r_head]) begin
                        r_valid[r_head] <= 1'b0;
                        o_kind       <= ruc_pkg::KIND_DELIVER;
                        o_number     <= r_next;
                        o_out_length <= r_rd.len;
                        o_out_tag    <= r_rd.tag;
                        o_final_res  <= r_rd.last;
                        o_run_end    <= 1'b0;
                        r_done       <= r_done | r_rd.last;
                        r_next       <= r_next + 1'b1;
                    end else begin
                        // gap reached: close the run with the ack
                        o_kind       <= ruc_pkg::KIND_ACK;
                        o_number     <= r_next;
                        o_out_length <= '0;
                        o_out_tag    <= '0;
                        o_final_res  <= r_done;
                        o_run_end    <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stat.next_expected = r_next;
    assign o_stat.done          = r_done;
    assign o_stat.busy          = (r_state != S_IDLE);

    `RUC_ASSERT_NOW(a_deliver_advances,
        o_strobe && (o_kind == ruc_pkg::KIND_DELIVER), r_next == o_number + 1'b1)
    `RUC_ASSERT_NOW(a_deliver_frees_slot,
        o_strobe && (o_kind == ruc_pkg::KIND_DELIVER), !r_valid[$past(r_head)])
    `RUC_ASSERT_NEXT(a_gap_acks,
        (r_state == S_DRAIN) && !r_valid[r_head], o_strobe && o_run_end)
    `RUC_ASSERT_NOW(a_ack_ends_run,
        o_strobe && o_run_end, (o_kind == ruc_pkg::KIND_ACK) && (r_state == S_IDLE))

endmodule

>>> rtl/reorder_buffer_cumulative_ack.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+-----------------------------------------------
// segment  | start / busy        | i_seq_num i_seg_length i_payload_tag i_last_segment
// result   | o_strobe (1 cycle)  | o_kind o_number o_out_length o_out_tag
//          |                     | o_final_res o_run_end
//
// A segment is taken when start is high and busy is low; busy stays high
// until its ack has been driven. Each segment passes through the front-end
// register and the command queue before its first result is registered,
// then one result a cycle: held segments drain at one per cycle through
// the registered slot read at head. Results cannot be stalled.
// Reset (i_rst_n low, synchronous) empties the window and sets next expected to 1.
// Top level: front end, command queue and back end. Uses ruc_pkg.
`timescale 1ns / 1ps
module reorder_buffer_cumulative_ack (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [ruc_pkg::SEQ_W-1:0]  i_seq_num,
    input  logic [ruc_pkg::LEN_W-1:0]  i_seg_length,
    input  logic [ruc_pkg::TAG_W-1:0]  i_payload_tag,
    input  logic                       i_last_segment,
    output logic                       o_strobe,
    output logic                       o_kind,
    output logic [ruc_pkg::SEQ_W-1:0]  o_number,
    output logic [ruc_pkg::LEN_W-1:0]  o_out_length,
    output logic [ruc_pkg::TAG_W-1:0]  o_out_tag,
    output logic                       o_final_res,
    output logic                       o_run_end
);

    ruc_pkg::t_seg        w_seg;
    ruc_pkg::t_cmd        w_front_cmd;
    ruc_pkg::t_cmd        w_queue_cmd;
    ruc_pkg::t_back_stat  w_stat;
    logic                 w_accept;
    logic                 w_front_valid;
    logic                 w_empty;
    logic                 w_pop;

    assign w_accept = start && !busy;
    assign w_seg    = '{seq: i_seq_num, len: i_seg_length, tag: i_payload_tag,
                        last: i_last_segment};

    // hold off new items until the current one has acked
    assign busy = w_front_valid || !w_empty || w_stat.busy;

    ruc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_seg    (w_seg),
        .i_stat   (w_stat),
        .o_valid  (w_front_valid),
        .o_cmd    (w_front_cmd)
    );

    ruc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_queue_cmd),
        .o_empty (w_empty)
    );

    ruc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_queue_cmd),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_stat       (w_stat),
        .o_strobe     (o_strobe),
        .o_kind       (o_kind),
        .o_number     (o_number),
        .o_out_length (o_out_length),
        .o_out_tag    (o_out_tag),
        .o_final_res  (o_final_res),
        .o_run_end    (o_run_end)
    );

endmodule

>>> tb/reorder_buffer_cumulative_ack_tb.sv
// Self-checking testbench for the reorder buffer with cumulative ack.
// Drives segments through start/busy and predicts every delivery and ack in step.
// Depends on ruc_pkg and the reorder_buffer_cumulative_ack RTL.
`timescale 1ns / 1ps
module reorder_buffer_cumulative_ack_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 230;
    localparam int N_DIR        = 14;
    localparam int WIN          = ruc_pkg::WINDOW;

    typedef struct {
        ruc_pkg::t_res_kind          kind;
        logic [ruc_pkg::SEQ_W-1:0]   number;
        logic [ruc_pkg::LEN_W-1:0]   len;
        logic [ruc_pkg::TAG_W-1:0]   tag;
        logic                        fin;
        logic                        run_end;
    } t_result;

    typedef struct {
        logic [ruc_pkg::SEQ_W-1:0]   seq;
        logic [ruc_pkg::LEN_W-1:0]   len;
        logic [ruc_pkg::TAG_W-1:0]   tag;
        logic                        last;
        bit                          check_ack;
        logic [ruc_pkg::SEQ_W-1:0]   ack_num;
        logic                        ack_done;
    } t_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [ruc_pkg::SEQ_W-1:0]   i_seq_num = '0;
    logic [ruc_pkg::LEN_W-1:0]   i_seg_length = '0;
    logic [ruc_pkg::TAG_W-1:0]   i_payload_tag = '0;
    logic                        i_last_segment = 1'b0;
    logic                        o_strobe;
    logic                        o_kind;
    logic [ruc_pkg::SEQ_W-1:0]   o_number;
    logic [ruc_pkg::LEN_W-1:0]   o_out_length;
    logic [ruc_pkg::TAG_W-1:0]   o_out_tag;
    logic                        o_final_res;
    logic                        o_run_end;

    // predicted receiver state
    logic [ruc_pkg::SEQ_W-1:0]   exp_next = 16'(ruc_pkg::SEQ_RESET);
    logic                        exp_done = 1'b0;
    logic [ruc_pkg::SLOT_W-1:0]  exp_head = '0;
    logic                        held_valid [WIN];
    logic [ruc_pkg::LEN_W-1:0]   held_len   [WIN];
    logic [ruc_pkg::TAG_W-1:0]   held_tag   [WIN];
    logic                        held_last  [WIN];

    t_result pending_results [$];
    t_result last_ack;

    int mismatch_count = 0;
    int seg_count = 0;
    int deliveries_seen = 0;
    int acks_seen = 0;
    int longest_drain = 0;
    int burst_left = 0;
    int cycle_count = 0;

    reorder_buffer_cumulative_ack u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_seq_num      (i_seq_num),
        .i_seg_length   (i_seg_length),
        .i_payload_tag  (i_payload_tag),
        .i_last_segment (i_last_segment),
        .o_strobe       (o_strobe),
        .o_kind         (o_kind),
        .o_number       (o_number),
        .o_out_length   (o_out_length),
        .o_out_tag      (o_out_tag),
        .o_final_res    (o_final_res),
        .o_run_end      (o_run_end)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void predict_segment(logic [ruc_pkg::SEQ_W-1:0] seq,
            logic [ruc_pkg::LEN_W-1:0] len_in, logic [ruc_pkg::TAG_W-1:0] tag,
            logic last);
        logic [ruc_pkg::SEQ_W-1:0]  offset;
        logic [ruc_pkg::LEN_W-1:0]  len;
        logic [ruc_pkg::SLOT_W-1:0] slot;
        int                         drained;
        len = (len_in > ruc_pkg::PAYLOAD_MAX) ? ruc_pkg::LEN_W'(ruc_pkg::PAYLOAD_MAX) : len_in;
        if (!exp_done) begin
            offset = seq - exp_next;
            if (offset == 0) begin
                held_valid[exp_head] = 1'b0;
                pending_results.push_back('{ruc_pkg::KIND_DELIVER, seq, len, tag, last, 1'b0});
                if (last)
                    exp_done = 1'b1;
                exp_next = exp_next + 1'b1;
                exp_head = exp_head + 1'b1;
                drained = 1;
                // drain every held segment that now follows without a gap
                while (held_valid[exp_head]) begin
                    held_valid[exp_head] = 1'b0;
                    pending_results.push_back('{ruc_pkg::KIND_DELIVER, exp_next,
                        held_len[exp_head], held_tag[exp_head], held_last[exp_head], 1'b0});
                    if (held_last[exp_head])
                        exp_done = 1'b1;
                    exp_next = exp_next + 1'b1;
                    exp_head = exp_head + 1'b1;
                    drained++;
                end
                if (drained > longest_drain)
                    longest_drain = drained;
            end else if (offset < WIN) begin
                slot = exp_head + offset[ruc_pkg::SLOT_W-1:0];
                held_valid[slot] = 1'b1;
                held_len[slot]   = len;
                held_tag[slot]   = tag;
                held_last[slot]  = last;
            end
        end
        last_ack = '{ruc_pkg::KIND_ACK, exp_next, '0, '0, exp_done, 1'b1};
        pending_results.push_back(last_ack);
    endfunction

    function automatic logic [ruc_pkg::LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return ruc_pkg::LEN_W'(ruc_pkg::PAYLOAD_MAX);
        else if (r == 1)
            return ruc_pkg::LEN_W'($urandom_range(ruc_pkg::PAYLOAD_MAX + 1, 2047));
        else if (r == 2)
            return '0;
        return ruc_pkg::LEN_W'($urandom_range(0, ruc_pkg::PAYLOAD_MAX));
    endfunction

    // Drive one segment, wait for it to be taken, then idle per the burst pattern.
    task automatic send_segment(input logic [ruc_pkg::SEQ_W-1:0] seq,
            input logic [ruc_pkg::LEN_W-1:0] len, input logic [ruc_pkg::TAG_W-1:0] tag,
            input logic last);
        int gap;
        start          <= 1'b1;
        i_seq_num      <= seq;
        i_seg_length   <= len;
        i_payload_tag  <= tag;
        i_last_segment <= last;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        predict_segment(seq, len, tag, last);
        seg_count++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result kind %0d number %0d length %0d tag %0d",
                         $time, o_kind, o_number, o_out_length, o_out_tag);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_kind !== want.kind) begin
                    $display("%0t: kind expected %0d actual %0d", $time, want.kind, o_kind);
                    mismatch_count++;
                end
                if (o_number !== want.number) begin
                    $display("%0t: number expected %0d actual %0d",
                             $time, want.number, o_number);
                    mismatch_count++;
                end
                if (o_out_length !== want.len) begin
                    $display("%0t: length expected %0d actual %0d",
                             $time, want.len, o_out_length);
                    mismatch_count++;
                end
                if (o_out_tag !== want.tag) begin
                    $display("%0t: tag expected %0d actual %0d", $time, want.tag, o_out_tag);
                    mismatch_count++;
                end
                if (o_final_res !== want.fin) begin
                    $display("%0t: final expected %0d actual %0d",
                             $time, want.fin, o_final_res);
                    mismatch_count++;
                end
                if (o_run_end !== want.run_end) begin
                    $display("%0t: run_end expected %0d actual %0d",
                             $time, want.run_end, o_run_end);
                    mismatch_count++;
                end
                if (want.kind == ruc_pkg::KIND_ACK)
                    acks_seen++;
                else
                    deliveries_seen++;
            end
        end
    end

    initial begin
        t_row dir_rows [N_DIR];
        int   offs [$];
        int   k, j, tmp, pick, dup_off, n, useful;
        logic [ruc_pkg::SEQ_W-1:0] base;

        // after reset next expected is 1; acks typed in where they are obvious
        dir_rows = '{
            '{16'd0,     11'd0,    8'd0,     1'b0, 1'b1, 16'd1, 1'b0},  // old
            '{16'd33,    11'd5,    8'd9,     1'b1, 1'b1, 16'd1, 1'b0},  // one past window
            '{16'd65535, 11'd2047, 8'd255,   1'b1, 1'b1, 16'd1, 1'b0},  // far
            '{16'd32,    11'd2047, 8'd255,   1'b0, 1'b1, 16'd1, 1'b0},  // window edge
            '{16'd3,     11'd1024, 8'h55,    1'b1, 1'b1, 16'd1, 1'b0},
            '{16'd3,     11'd5,    8'hAA,    1'b0, 1'b1, 16'd1, 1'b0},  // overwrite
            '{16'd2,     11'd1025, 8'd1,     1'b0, 1'b1, 16'd1, 1'b0},
            '{16'd1,     11'd0,    8'd0,     1'b0, 1'b1, 16'd4, 1'b0},  // drains 1..3
            '{16'd1,     11'd7,    8'd7,     1'b0, 1'b1, 16'd4, 1'b0},  // stale repeat
            '{16'd4,     11'd1024, 8'd0,     1'b0, 1'b1, 16'd5, 1'b0},
            '{16'd6,     11'd11,   8'd22,    1'b0, 1'b0, 16'd0, 1'b0},
            '{16'd7,     11'd12,   8'd23,    1'b0, 1'b0, 16'd0, 1'b0},
            '{16'd5,     11'd10,   8'd21,    1'b0, 1'b1, 16'd8, 1'b0},
            '{16'd8,     11'd2047, 8'd128,   1'b0, 1'b1, 16'd9, 1'b0}
        };
        foreach (held_valid[i]) begin
            held_valid[i] = 1'b0;
            held_len[i]   = '0;
            held_tag[i]   = '0;
            held_last[i]  = 1'b0;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            send_segment(dir_rows[i].seq, dir_rows[i].len, dir_rows[i].tag, dir_rows[i].last);
            if (dir_rows[i].check_ack && (last_ack.number !== dir_rows[i].ack_num ||
                    last_ack.fin !== dir_rows[i].ack_done)) begin
                $display("%0t: row %0d ack expected %0d/%0d actual %0d/%0d", $time, i,
                         dir_rows[i].ack_num, dir_rows[i].ack_done,
                         last_ack.number, last_ack.fin);
                mismatch_count++;
            end
        end

        // random part: mostly window fills that end in a drain
        useful = 0;
        while (useful < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            base = exp_next;
            if (pick <= 5) begin
                k = ($urandom_range(0, 6) == 0) ? WIN - 1 : $urandom_range(1, 8);
                offs.delete();
                for (int i = 1; i <= k; i++)
                    offs.push_back(i);
                for (int i = k - 1; i > 0; i--) begin
                    j = $urandom_range(0, i);
                    tmp = offs[i];
                    offs[i] = offs[j];
                    offs[j] = tmp;
                end
                dup_off = ($urandom_range(0, 2) == 0) ? $urandom_range(1, k) : 0;
                foreach (offs[i]) begin
                    // a held copy marked last, replaced before it can drain
                    if (offs[i] == dup_off) begin
                        send_segment(base + 16'(offs[i]), pick_length(),
                                     8'($urandom_range(0, 255)), 1'b1);
                        useful++;
                    end
                    send_segment(base + 16'(offs[i]), pick_length(),
                                 8'($urandom_range(0, 255)), 1'b0);
                    useful++;
                end
                send_segment(base, pick_length(), 8'($urandom_range(0, 255)), 1'b0);
                useful++;
            end else if (pick <= 7) begin
                n = $urandom_range(1, 3);
                repeat (n) begin
                    send_segment(base + 16'($urandom_range(WIN, 65535)), pick_length(),
                                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    useful++;
                end
            end else if (pick == 8) begin
                send_segment(base, pick_length(), 8'($urandom_range(0, 255)), 1'b0);
                useful++;
            end else begin
                n = $urandom_range(1, 3);
                repeat (n) begin
                    send_segment(base + 16'($urandom_range(1, WIN - 1)), pick_length(),
                                 8'($urandom_range(0, 255)), 1'b0);
                    useful++;
                end
            end
        end

        // finish the file: end marker held, then the gap filled in
        base = exp_next;
        send_segment(base + 16'd2, pick_length(), 8'($urandom_range(0, 255)), 1'b1);
        send_segment(base + 16'd1, pick_length(), 8'($urandom_range(0, 255)), 1'b0);
        send_segment(base, pick_length(), 8'($urandom_range(0, 255)), 1'b0);
        send_segment(exp_next, pick_length(), 8'($urandom_range(0, 255)), 1'b1);
        repeat (3)
            send_segment(16'($urandom_range(0, 65535)), pick_length(),
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (WIN + 8) @(posedge i_clk);

        $display("Sent %0d segments; checked %0d deliveries and %0d acks", seg_count,
                 deliveries_seen, acks_seen);
        $display("Longest in-order run %0d, transfer done %0d", longest_drain, exp_done);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
